/* sv/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// mexp_pkg
// shared constants and types for the modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int MEXP_WIDTH = 15;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_FINISH
    } mexp_state_t;

endpackage

/* sv/mexp_channels.sv */
// ----------------------------------------------------------------------------
// mexp channels
// valid/ready channels for operands, results and the modulus register write
// ----------------------------------------------------------------------------
interface mexp_operand_if #(parameter int W = mexp_pkg::MEXP_WIDTH) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] base_value;
    logic [W-1:0] exponent;

    modport source (output valid, output base_value, output exponent, input ready);
    modport sink (input valid, input base_value, input exponent, output ready);
endinterface

interface mexp_result_if #(parameter int W = mexp_pkg::MEXP_WIDTH) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink (input valid, input power_result, output ready);
endinterface

interface mexp_cfg_if #(parameter int W = mexp_pkg::MEXP_WIDTH) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/modular_exponentiation.sv */
// one item at a time: operands are taken only in idle, and each item runs on the bit-serial
//   modular multiplier as one reduction of the base, then one square per exponent bit plus
//   one multiply per set bit; a modulus below two gives a zero result with no multiply
// reset: modulus register returns to 2, control idles, no result pending
// ----------------------------------------------------------------------------
// modular_exponentiation
// square-and-multiply exponentiation over a shared bit-serial modular multiplier
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int OPERAND_WIDTH = mexp_pkg::MEXP_WIDTH
) (
    input logic            clk,
    input logic            rst_n,
    mexp_cfg_if.sink       cfg,
    mexp_operand_if.sink   operands,
    mexp_result_if.source  result
);

    import mexp_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W + 1);

    mexp_state_t   state_reg, state_next;
    logic [W-1:0]  modulus_reg;
    logic          out_valid_reg, out_valid_next;
    logic [W-1:0]  result_reg;
    logic [CW-1:0] bit_cnt_reg, bit_cnt_next;
    logic [W-1:0]  exp_reg, exp_next;
    logic [W-1:0]  base_reg, base_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic          load_result;

    logic          mm_start;
    logic [W-1:0]  mm_a;
    logic [W-1:0]  mm_b;
    logic          mm_done;
    logic [W-1:0]  mm_product;

    logic [W-1:0]  one_value;
    logic          modulus_small;

    assign one_value     = {{(W-1){1'b0}}, 1'b1};
    assign modulus_small = (modulus_reg[W-1:1] == '0);

    mexp_mulmod #(
        .W (W)
    ) u_mulmod (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mm_start),
        .multiplicand (mm_a),
        .multiplier   (mm_b),
        .modulus      (modulus_reg),
        .done         (mm_done),
        .product      (mm_product)
    );

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        exp_next     = exp_reg;
        base_next    = base_reg;
        acc_next     = acc_reg;
        mm_start     = 1'b0;
        mm_a         = acc_reg;
        mm_b         = acc_reg;
        load_result  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (operands.valid)
                begin
                    exp_next     = operands.exponent;
                    bit_cnt_next = CW'(W);
                    if (modulus_small)
                    begin
                        acc_next   = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        // base mod m as base * 1 mod m
                        acc_next   = one_value;
                        mm_start   = 1'b1;
                        mm_a       = one_value;
                        mm_b       = operands.base_value;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (mm_done)
                begin
                    base_next  = mm_product;
                    mm_start   = 1'b1;
                    mm_a       = acc_reg;
                    mm_b       = acc_reg;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (mm_done)
                begin
                    acc_next = mm_product;
                    if (exp_reg[W-1])
                    begin
                        mm_start   = 1'b1;
                        mm_a       = base_reg;
                        mm_b       = mm_product;
                        state_next = ST_MULT;
                    end
                    else
                    begin
                        exp_next     = {exp_reg[W-2:0], 1'b0};
                        bit_cnt_next = bit_cnt_reg - 1'b1;
                        if (bit_cnt_reg == CW'(1))
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            mm_start = 1'b1;
                            mm_a     = mm_product;
                            mm_b     = mm_product;
                        end
                    end
                end
            end
            ST_MULT:
            begin
                if (mm_done)
                begin
                    acc_next     = mm_product;
                    exp_next     = {exp_reg[W-2:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                    if (bit_cnt_reg == CW'(1))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        mm_start   = 1'b1;
                        mm_a       = mm_product;
                        mm_b       = mm_product;
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_FINISH:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || result.ready)
                begin
                    load_result = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_result | (out_valid_reg & ~result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            modulus_reg   <= W'(2);
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            if (cfg.valid)
            begin
                modulus_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg  <= exp_next;
        base_reg <= base_next;
        acc_reg  <= acc_next;
        if (load_result)
        begin
            result_reg <= acc_reg;
        end
    end

    assign cfg.ready           = 1'b1;
    assign operands.ready      = (state_reg == ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.power_result = result_reg;

endmodule

/* sv/mexp_mulmod.sv */
// ----------------------------------------------------------------------------
// mexp_mulmod
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
// ----------------------------------------------------------------------------
module mexp_mulmod #(
    parameter int W = mexp_pkg::MEXP_WIDTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] multiplicand,
    input  logic [W-1:0] multiplier,
    input  logic [W-1:0] modulus,
    output logic         done,
    output logic [W-1:0] product
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  a_reg, m_reg, sh_reg, r_reg;

    logic [W+1:0]  sum;
    logic [W+1:0]  m1;
    logic [W+1:0]  m2;
    logic [W+1:0]  diff1;
    logic [W+1:0]  diff2;
    logic [W-1:0]  r_step;

    // r = (2r + bit * a) mod m, with r < m and a < m so at most 2m is removed
    assign m1    = {2'b00, m_reg};
    assign m2    = {1'b0, m_reg, 1'b0};
    assign sum   = {1'b0, r_reg, 1'b0} + {2'b00, (sh_reg[W-1] ? a_reg : '0)};
    assign diff1 = sum - m1;
    assign diff2 = sum - m2;

    always_comb
    begin
        if (sum >= m2)
        begin
            r_step = diff2[W-1:0];
        end
        else if (sum >= m1)
        begin
            r_step = diff1[W-1:0];
        end
        else
        begin
            r_step = sum[W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= multiplicand;
            m_reg  <= modulus;
            sh_reg <= multiplier;
            r_reg  <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg <= {sh_reg[W-2:0], 1'b0};
            r_reg  <= r_step;
        end
    end

    assign done    = done_reg;
    assign product = r_reg;

endmodule
